@@ rtl/core/drwt_pkg.sv @@
// Shared types and codes for the dirty revision write tracker.
// No dependencies.
package drwt_pkg;

  typedef enum logic [2:0] {
    MODE_MARK     = 3'd0,
    MODE_RESTORE  = 3'd1,
    MODE_COMPLETE = 3'd2,
    MODE_TAKE_URG = 3'd3,
    MODE_TAKE_DUE = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } op_status_e;

  localparam int unsigned FieldBits = 32;
  localparam int unsigned OccBits   = 5;

  // Decoded command handed from the front part to the back part.
  typedef struct packed {
    logic [2:0]           mode;
    logic [FieldBits-1:0] key;
    logic [FieldBits-1:0] rec;
    logic [FieldBits-1:0] rev;
    logic                 sm;
    logic                 ss;
    logic                 st;
    logic                 urg;
    logic [FieldBits-1:0] now;
  } cmd_t;

endpackage

@@ rtl/core/drwt_front.sv @@
// Front part: accepts items, masks revision and time to the configured widths, queues them.
// Depends on drwt_pkg.
module drwt_front #(
  parameter int unsigned REVISION_BITS = 32,
  parameter int unsigned TIME_BITS     = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   mode_i,
  input  logic [31:0]                  key_i,
  input  logic [31:0]                  record_handle_i,
  input  logic [31:0]                  revision_i,
  input  logic                         sel_metadata_i,
  input  logic                         sel_status_i,
  input  logic                         sel_telemetry_i,
  input  logic                         want_urgent_i,
  input  logic [31:0]                  now_time_i,
  output logic                         cmd_valid_o,
  input  logic                         cmd_ready_i,
  output drwt_pkg::cmd_t               cmd_o
);
  import drwt_pkg::*;

  localparam int unsigned RB = (REVISION_BITS < 32) ? REVISION_BITS : 32;
  localparam int unsigned TB = (TIME_BITS < 32) ? TIME_BITS : 32;
  localparam logic [31:0] RevMask = 32'hFFFF_FFFF >> (32 - RB);
  localparam logic [31:0] TimeMask = 32'hFFFF_FFFF >> (32 - TB);

  // two-entry queue
  cmd_t       q_q [2];
  logic [1:0] cnt_q;
  logic       rd_q;
  logic       push, pop;
  cmd_t       c;

  always_comb begin
    c.mode = mode_i;
    c.key  = key_i;
    c.rec  = record_handle_i;
    c.rev  = revision_i & RevMask;
    c.sm   = sel_metadata_i;
    c.ss   = sel_status_i;
    c.st   = sel_telemetry_i;
    c.urg  = want_urgent_i;
    c.now  = now_time_i & TimeMask;
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
    end else begin
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_q[rd_q ^ cnt_q[0]] <= c;
  end

endmodule

@@ rtl/core/drwt_back.sv @@
// Back part: entry table, key lookup, update and slot scan for takes.
// Depends on drwt_pkg.
module drwt_back #(
  parameter int unsigned TABLE_SLOTS = 16,
  parameter int unsigned TIME_BITS   = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [31:0]     interval_ticks_i,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  drwt_pkg::cmd_t  cmd_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            has_entry_o,
  output logic [31:0]     out_key_o,
  output logic [31:0]     out_record_o,
  output logic [31:0]     out_revision_o,
  output logic            out_metadata_o,
  output logic            out_status_o,
  output logic            out_telemetry_o,
  output logic            out_urgent_o,
  output logic [1:0]      op_status_o,
  output logic [4:0]      occupancy_o,
  output logic            last_o
);
  import drwt_pkg::*;

  localparam int unsigned IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned TB = (TIME_BITS < 32) ? TIME_BITS : 32;
  localparam logic [31:0] TimeMask = 32'hFFFF_FFFF >> (32 - TB);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_SCAN = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [TABLE_SLOTS-1:0] valid_q;
  logic [31:0] key_q   [TABLE_SLOTS];
  logic [31:0] rec_q   [TABLE_SLOTS];
  logic [31:0] rev_q   [TABLE_SLOTS];
  logic [31:0] dm_q    [TABLE_SLOTS];
  logic [31:0] ds_q    [TABLE_SLOTS];
  logic [31:0] dt_q    [TABLE_SLOTS];
  logic [31:0] fm_q    [TABLE_SLOTS];
  logic [31:0] fs_q    [TABLE_SLOTS];
  logic [31:0] ft_q    [TABLE_SLOTS];
  logic        urg_q   [TABLE_SLOTS];
  logic [31:0] mt_q    [TABLE_SLOTS];

  cmd_t        cmd_q;
  logic [IW:0] idx_q;
  logic        any_q;
  logic [1:0]  wst_q;
  logic [CW-1:0] occ;

  // result register
  logic        ovalid_q;
  logic        has_q, om_q, os_q, ot_q, ou_q, last_q;
  logic [31:0] ok_q, orec_q, orev_q;
  logic [1:0]  ost_q;
  logic [4:0]  oocc_q;

  // dispatched entry held back until the scan knows whether it is the final one
  logic        hm_q, hs_q, ht_q, hu_q;
  logic [31:0] hk_q, hrec_q, hrev_q;

  // lookup
  logic          hit, freef;
  logic [IW-1:0] hidx, fidx;

  always_comb begin
    hit = 1'b0; freef = 1'b0; hidx = '0; fidx = '0;
    occ = '0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (valid_q[i] && key_q[i] == cmd_q.key) begin
        hit = 1'b1; hidx = IW'(i);
      end
      if (!valid_q[i]) begin
        freef = 1'b1; fidx = IW'(i);
      end
    end
    for (int i = 0; i < TABLE_SLOTS; i++) occ = occ + CW'(valid_q[i]);
  end

  logic [IW-1:0] si;
  logic          sdirty, selig;
  logic [31:0]   age;
  assign si     = idx_q[IW-1:0];
  assign age    = (cmd_q.now - mt_q[si]) & TimeMask;
  assign sdirty = (dm_q[si] != 0) || (ds_q[si] != 0) || (dt_q[si] != 0);
  assign selig  = valid_q[si] && sdirty &&
                  (urg_q[si] == (cmd_q.mode == MODE_TAKE_URG)) &&
                  ((cmd_q.mode == MODE_TAKE_URG) || (age >= interval_ticks_i));

  logic scan_end;
  assign scan_end = (idx_q == (IW + 1)'(TABLE_SLOTS - 1));

  logic oslot_free, scan_go, emit_scan, emit_out;
  assign oslot_free = !ovalid_q || out_ready_i;
  // a new hit pushes the held entry out, so it waits for a free output register
  assign scan_go    = !(selig && any_q && !oslot_free);
  assign emit_scan  = (state_q == S_SCAN) && selig && any_q && oslot_free;
  assign emit_out   = (state_q == S_OUT) && oslot_free;

  assign cmd_ready_o = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (cmd_valid_i) state_d = S_LOOK;
      S_LOOK: state_d = S_OUT;
      S_SCAN: if (scan_go && scan_end) state_d = S_OUT;
      S_OUT:  if (oslot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_LOOK &&
        (cmd_q.mode == MODE_TAKE_URG || cmd_q.mode == MODE_TAKE_DUE))
      state_d = S_SCAN;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      valid_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= emit_scan || emit_out || (ovalid_q && !out_ready_i);
      case (state_q)
        S_LOOK: begin
          if ((cmd_q.mode == MODE_MARK || cmd_q.mode == MODE_RESTORE) && !hit && freef)
            valid_q[fidx] <= 1'b1;
          if (cmd_q.mode == MODE_COMPLETE && hit &&
              dm_q[hidx] == 0 && ds_q[hidx] == 0 && dt_q[hidx] == 0 &&
              (fm_q[hidx] == 0 || (cmd_q.sm && fm_q[hidx] <= cmd_q.rev)) &&
              (fs_q[hidx] == 0 || (cmd_q.ss && fs_q[hidx] <= cmd_q.rev)) &&
              (ft_q[hidx] == 0 || (cmd_q.st && ft_q[hidx] <= cmd_q.rev)))
            valid_q[hidx] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  logic [IW-1:0] ws;
  logic          isnew;
  assign isnew = !hit;
  assign ws    = hit ? hidx : fidx;

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        cmd_q <= cmd_i;
        idx_q <= '0;
        any_q <= 1'b0;
        wst_q <= ST_OK;
      end
      S_LOOK: begin
        if (cmd_q.mode == MODE_MARK || cmd_q.mode == MODE_RESTORE) begin
          if (!hit && !freef) wst_q <= ST_FULL;
          else begin
            if (isnew || cmd_q.rev >= rev_q[ws]) begin
              rec_q[ws] <= cmd_q.rec;
              rev_q[ws] <= cmd_q.rev;
            end
            if (isnew) key_q[ws] <= cmd_q.key;
            urg_q[ws] <= cmd_q.urg || (!isnew && urg_q[ws]);
            if (cmd_q.mode == MODE_MARK) begin
              dm_q[ws] <= (cmd_q.sm && (isnew || cmd_q.rev > dm_q[ws])) ? cmd_q.rev :
                          (isnew ? 32'd0 : dm_q[ws]);
              ds_q[ws] <= (cmd_q.ss && (isnew || cmd_q.rev > ds_q[ws])) ? cmd_q.rev :
                          (isnew ? 32'd0 : ds_q[ws]);
              dt_q[ws] <= (cmd_q.st && (isnew || cmd_q.rev > dt_q[ws])) ? cmd_q.rev :
                          (isnew ? 32'd0 : dt_q[ws]);
              if (isnew) begin
                fm_q[ws] <= '0; fs_q[ws] <= '0; ft_q[ws] <= '0;
              end
              if (isnew || (cmd_q.st && dt_q[ws] == 0)) mt_q[ws] <= cmd_q.now;
            end else begin
              if (cmd_q.sm) begin
                dm_q[ws] <= (!isnew && dm_q[ws] > cmd_q.rev) ? dm_q[ws] : cmd_q.rev;
                if (isnew || fm_q[ws] <= cmd_q.rev) fm_q[ws] <= '0;
              end else if (isnew) begin
                dm_q[ws] <= '0; fm_q[ws] <= '0;
              end
              if (cmd_q.ss) begin
                ds_q[ws] <= (!isnew && ds_q[ws] > cmd_q.rev) ? ds_q[ws] : cmd_q.rev;
                if (isnew || fs_q[ws] <= cmd_q.rev) fs_q[ws] <= '0;
              end else if (isnew) begin
                ds_q[ws] <= '0; fs_q[ws] <= '0;
              end
              if (cmd_q.st) begin
                dt_q[ws] <= (!isnew && dt_q[ws] > cmd_q.rev) ? dt_q[ws] : cmd_q.rev;
                if (isnew || ft_q[ws] <= cmd_q.rev) ft_q[ws] <= '0;
              end else if (isnew) begin
                dt_q[ws] <= '0; ft_q[ws] <= '0;
              end
              if (isnew) mt_q[ws] <= cmd_q.now;
            end
          end
        end else if (cmd_q.mode == MODE_COMPLETE) begin
          if (!hit) wst_q <= ST_NOTFOUND;
          else begin
            if (cmd_q.sm && fm_q[hidx] <= cmd_q.rev) fm_q[hidx] <= '0;
            if (cmd_q.ss && fs_q[hidx] <= cmd_q.rev) fs_q[hidx] <= '0;
            if (cmd_q.st && ft_q[hidx] <= cmd_q.rev) ft_q[hidx] <= '0;
          end
        end
      end
      S_SCAN: begin
        if (scan_go) begin
          if (selig) begin
            // release the previously held entry, it is not the final one
            if (any_q) begin
              has_q  <= 1'b1;
              ok_q   <= hk_q;
              orec_q <= hrec_q;
              orev_q <= hrev_q;
              om_q   <= hm_q;
              os_q   <= hs_q;
              ot_q   <= ht_q;
              ou_q   <= hu_q;
              last_q <= 1'b0;
              ost_q  <= wst_q;
              oocc_q <= 5'(occ);
            end
            any_q  <= 1'b1;
            hk_q   <= key_q[si];
            hrec_q <= rec_q[si];
            hrev_q <= rev_q[si];
            hm_q   <= dm_q[si] != 0;
            hs_q   <= ds_q[si] != 0;
            ht_q   <= dt_q[si] != 0;
            hu_q   <= urg_q[si];
            if (dm_q[si] > fm_q[si]) fm_q[si] <= dm_q[si];
            if (ds_q[si] > fs_q[si]) fs_q[si] <= ds_q[si];
            if (dt_q[si] > ft_q[si]) ft_q[si] <= dt_q[si];
            dm_q[si] <= '0; ds_q[si] <= '0; dt_q[si] <= '0;
            urg_q[si] <= 1'b0;
          end
          if (!scan_end) idx_q <= idx_q + (IW + 1)'(1);
        end
      end
      S_OUT: begin
        // final result of the item: the held entry, or an empty one
        if (oslot_free) begin
          has_q  <= any_q;
          ok_q   <= any_q ? hk_q : '0;
          orec_q <= any_q ? hrec_q : '0;
          orev_q <= any_q ? hrev_q : '0;
          om_q   <= any_q && hm_q;
          os_q   <= any_q && hs_q;
          ot_q   <= any_q && ht_q;
          ou_q   <= any_q && hu_q;
          last_q <= 1'b1;
          ost_q  <= wst_q;
          oocc_q <= 5'(occ);
        end
      end
      default: ;
    endcase
  end

  assign has_entry_o     = has_q;
  assign out_key_o       = ok_q;
  assign out_record_o    = orec_q;
  assign out_revision_o  = orev_q;
  assign out_metadata_o  = om_q;
  assign out_status_o    = os_q;
  assign out_telemetry_o = ot_q;
  assign out_urgent_o    = ou_q;
  assign op_status_o     = ost_q;
  assign occupancy_o     = oocc_q;
  assign last_o          = last_q;

endmodule

@@ rtl/core/dirty_revision_write_tracker.sv @@
// Dirty revision write tracker, top level: front queue plus back table.
// Depends on drwt_pkg, drwt_front, drwt_back.
// A mark, restore or complete is registered in the front queue, then passes the
// back part's IDLE, LOOK and OUT states; the back part takes no new item before IDLE.
// A take walks one slot a cycle while no new hit waits for a free output register.
// A two-entry queue in front holds the next transactions while the back part works.
// Reset clears all valid bits and control; entry contents are not cleared.
module dirty_revision_write_tracker #(
  parameter int unsigned TABLE_SLOTS   = 16,
  parameter int unsigned REVISION_BITS = 32,
  parameter int unsigned TIME_BITS     = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [31:0] key_i,
  input  logic [31:0] record_handle_i,
  input  logic [31:0] revision_i,
  input  logic        sel_metadata_i,
  input  logic        sel_status_i,
  input  logic        sel_telemetry_i,
  input  logic        want_urgent_i,
  input  logic [31:0] now_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        has_entry_o,
  output logic [31:0] out_key_o,
  output logic [31:0] out_record_o,
  output logic [31:0] out_revision_o,
  output logic        out_metadata_o,
  output logic        out_status_o,
  output logic        out_telemetry_o,
  output logic        out_urgent_o,
  output logic [1:0]  op_status_o,
  output logic [4:0]  occupancy_o,
  output logic        last_o
);
  import drwt_pkg::*;

  logic [31:0] interval_q;
  logic        cvalid, cready;
  cmd_t        cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) interval_q <= '0;
    else if (cfg_we_i) interval_q <= cfg_wdata_i;
  end

  drwt_front #(.REVISION_BITS(REVISION_BITS), .TIME_BITS(TIME_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .mode_i, .key_i, .record_handle_i,
    .revision_i, .sel_metadata_i, .sel_status_i, .sel_telemetry_i, .want_urgent_i,
    .now_time_i, .cmd_valid_o(cvalid), .cmd_ready_i(cready), .cmd_o(cmd)
  );

  drwt_back #(.TABLE_SLOTS(TABLE_SLOTS), .TIME_BITS(TIME_BITS)) u_back (
    .clk_i, .rst_ni, .interval_ticks_i(interval_q), .cmd_valid_i(cvalid),
    .cmd_ready_o(cready), .cmd_i(cmd), .out_valid_o, .out_ready_i, .has_entry_o,
    .out_key_o, .out_record_o, .out_revision_o, .out_metadata_o, .out_status_o,
    .out_telemetry_o, .out_urgent_o, .op_status_o, .occupancy_o, .last_o
  );

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for dirty_revision_write_tracker: random and directed
// transactions, an in-bench slot table predictor and an in-order result check.
// Depends on drwt_pkg and the RTL of the tracker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import drwt_pkg::*;

  localparam int Slots = 16;
  localparam int KeyPool = 20;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] key;
    logic [31:0] rec;
    logic [31:0] rev;
    logic        sm;
    logic        ss;
    logic        st;
    logic        urg;
    logic [31:0] now;
  } write_req_t;

  typedef struct packed {
    logic        has_entry;
    logic [31:0] key;
    logic [31:0] rec;
    logic [31:0] rev;
    logic        meta;
    logic        stat;
    logic        telem;
    logic        urgent;
    logic [1:0]  status;
    logic [4:0]  occ;
    logic        last;
  } dispatch_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [2:0] mode_i;
  logic [31:0] key_i, record_handle_i, revision_i, now_time_i;
  logic sel_metadata_i, sel_status_i, sel_telemetry_i, want_urgent_i;
  logic has_entry_o, out_metadata_o, out_status_o, out_telemetry_o, out_urgent_o, last_o;
  logic [31:0] out_key_o, out_record_o, out_revision_o;
  logic [1:0] op_status_o;
  logic [4:0] occupancy_o;

  dirty_revision_write_tracker dut (.*);

  // predictor copy of the table
  bit          tv_valid [Slots];
  bit [31:0]   tv_key [Slots], tv_rec [Slots], tv_rev [Slots], tv_mark [Slots];
  bit [31:0]   tv_dirty [Slots][3], tv_flight [Slots][3];
  bit          tv_urgent [Slots];
  bit [31:0]   interval_ticks;

  write_req_t  pending_writes [$];
  dispatch_t   expected_results [$];
  write_req_t  on_bus;
  int          snd_idle, rcv_idle;
  int          errors, items_done, entries_seen, full_drops, cycles;
  bit          long_stall_go, long_stall_done;
  int          stall_left;
  bit [31:0]   key_pool [KeyPool];
  bit [31:0]   tick;

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void add_expected(dispatch_t r);
    expected_results = {expected_results, r};
  endfunction

  function automatic void add_write(write_req_t w);
    pending_writes = {pending_writes, w};
  endfunction

  function automatic bit [4:0] live_count();
    bit [4:0] n = 0;
    for (int i = 0; i < Slots; i++) if (tv_valid[i]) n++;
    return n;
  endfunction

  function automatic dispatch_t result_for(int idx, op_status_e st, bit lst);
    dispatch_t r = '0;
    if (idx >= 0) begin
      r.has_entry = 1;
      r.key = tv_key[idx];
      r.rec = tv_rec[idx];
      r.rev = tv_rev[idx];
      r.meta = tv_dirty[idx][0] != 0;
      r.stat = tv_dirty[idx][1] != 0;
      r.telem = tv_dirty[idx][2] != 0;
      r.urgent = tv_urgent[idx];
    end
    r.status = st;
    r.occ = live_count();
    r.last = lst;
    return r;
  endfunction

  function automatic bit slot_dirty(int i);
    return tv_dirty[i][0] != 0 || tv_dirty[i][1] != 0 || tv_dirty[i][2] != 0;
  endfunction

  // Work out the results of one accepted write request and update the table.
  function automatic void predict_dispatches(write_req_t w);
    int s;
    int n;
    bit sel [3];
    bit telem_was, want_imm;
    sel[0] = w.sm; sel[1] = w.ss; sel[2] = w.st;
    s = -1;
    n = 0;
    for (int i = 0; i < Slots; i++)
      if (s < 0 && tv_valid[i] && tv_key[i] == w.key) s = i;
    if (w.mode == MODE_MARK || w.mode == MODE_RESTORE) begin
      if (s < 0) begin
        for (int i = 0; i < Slots; i++) if (s < 0 && !tv_valid[i]) s = i;
        if (s < 0) begin
          full_drops++;
          add_expected(result_for(-1, ST_FULL, 1));
          return;
        end
        tv_valid[s] = 1;
        tv_key[s] = w.key;
        tv_rec[s] = w.rec;
        tv_rev[s] = w.rev;
        for (int f = 0; f < 3; f++) begin
          tv_dirty[s][f] = 0;
          tv_flight[s][f] = 0;
        end
        tv_urgent[s] = 0;
        tv_mark[s] = w.now;
      end else if (w.rev >= tv_rev[s]) begin
        tv_rec[s] = w.rec;
        tv_rev[s] = w.rev;
      end
      telem_was = tv_dirty[s][2] != 0;
      for (int f = 0; f < 3; f++)
        if (sel[f]) begin
          if (w.mode == MODE_RESTORE && tv_flight[s][f] <= w.rev) tv_flight[s][f] = 0;
          if (w.rev > tv_dirty[s][f]) tv_dirty[s][f] = w.rev;
        end
      if (w.mode == MODE_MARK && w.st && !telem_was) tv_mark[s] = w.now;
      if (w.urg) tv_urgent[s] = 1;
      add_expected(result_for(-1, ST_OK, 1));
    end else if (w.mode == MODE_COMPLETE) begin
      if (s < 0) begin
        add_expected(result_for(-1, ST_NOTFOUND, 1));
        return;
      end
      for (int f = 0; f < 3; f++)
        if (sel[f] && tv_flight[s][f] != 0 && tv_flight[s][f] <= w.rev) tv_flight[s][f] = 0;
      if (!slot_dirty(s) && tv_flight[s][0] == 0 && tv_flight[s][1] == 0 &&
          tv_flight[s][2] == 0)
        tv_valid[s] = 0;
      add_expected(result_for(-1, ST_OK, 1));
    end else if (w.mode == MODE_TAKE_URG || w.mode == MODE_TAKE_DUE) begin
      want_imm = w.mode == MODE_TAKE_URG;
      for (int i = 0; i < Slots; i++) begin
        if (!tv_valid[i] || !slot_dirty(i) || tv_urgent[i] != want_imm) continue;
        if (!want_imm && (w.now - tv_mark[i]) < interval_ticks) continue;
        add_expected(result_for(i, ST_OK, 0));
        n++;
        for (int f = 0; f < 3; f++) begin
          if (tv_dirty[i][f] > tv_flight[i][f]) tv_flight[i][f] = tv_dirty[i][f];
          tv_dirty[i][f] = 0;
        end
        tv_urgent[i] = 0;
      end
      if (n == 0) add_expected(result_for(-1, ST_OK, 1));
      else expected_results[$].last = 1;
    end else begin
      add_expected(result_for(-1, ST_OK, 1));
    end
  endfunction

  // Driver: hold valid and payload until the transaction is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 0;
      on_bus <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_dispatches(on_bus);
        items_done++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_writes.size() > 0 && $urandom_range(99) >= snd_idle) begin
          in_valid_i <= 1;
          on_bus <= pending_writes.pop_front();
        end else begin
          in_valid_i <= 0;
        end
      end
    end
  end

  assign mode_i = on_bus.mode;
  assign key_i = on_bus.key;
  assign record_handle_i = on_bus.rec;
  assign revision_i = on_bus.rev;
  assign sel_metadata_i = on_bus.sm;
  assign sel_status_i = on_bus.ss;
  assign sel_telemetry_i = on_bus.st;
  assign want_urgent_i = on_bus.urg;
  assign now_time_i = on_bus.now;

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
    end
  endfunction

  // Monitor: random back-pressure, one long hold-off, in-order checking.
  always @(posedge clk_i or negedge rst_ni) begin
    dispatch_t e;
    if (!rst_ni) begin
      out_ready_i <= 0;
      stall_left <= 0;
      long_stall_done <= 0;
    end else begin
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles", cycles);
        $display("testbench: FAIL");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, key %0h status %0d", $time, out_key_o,
                   op_status_o);
        end else begin
          e = expected_results.pop_front();
          if (e.has_entry) entries_seen++;
          check_field("has_entry", e.has_entry, has_entry_o);
          check_field("out_key", e.key, out_key_o);
          check_field("out_record", e.rec, out_record_o);
          check_field("out_revision", e.rev, out_revision_o);
          check_field("out_metadata", e.meta, out_metadata_o);
          check_field("out_status", e.stat, out_status_o);
          check_field("out_telemetry", e.telem, out_telemetry_o);
          check_field("out_urgent", e.urgent, out_urgent_o);
          check_field("op_status", e.status, op_status_o);
          check_field("occupancy", e.occ, occupancy_o);
          check_field("last", e.last, last_o);
        end
      end
      if (long_stall_go && !long_stall_done) begin
        long_stall_done <= 1;
        stall_left <= 400;
        out_ready_i <= 0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready_i <= 0;
      end else begin
        out_ready_i <= $urandom_range(99) >= rcv_idle;
      end
    end
  end

  function automatic write_req_t make_req(logic [2:0] m, logic [31:0] k, logic [31:0] r,
                                          logic [2:0] sel, logic u);
    write_req_t w;
    w.mode = m;
    w.key = k;
    w.rec = $urandom;
    w.rev = r;
    {w.sm, w.ss, w.st} = sel;
    w.urg = u;
    tick += $urandom_range(0, 6);
    w.now = tick;
    return w;
  endfunction

  function automatic write_req_t random_req();
    int p;
    logic [2:0] m;
    logic [31:0] r;
    p = $urandom_range(99);
    if (p < 40) m = MODE_MARK;
    else if (p < 55) m = MODE_RESTORE;
    else if (p < 80) m = MODE_COMPLETE;
    else if (p < 88) m = MODE_TAKE_URG;
    else if (p < 96) m = MODE_TAKE_DUE;
    else m = 3'($urandom_range(5, 7));
    p = $urandom_range(99);
    if (p < 5) r = 0;
    else if (p < 12) r = $urandom;
    else r = $urandom_range(1, 40);
    if ($urandom_range(19) == 0) tick += $urandom;
    return make_req(m, key_pool[$urandom_range(KeyPool - 1)], r, 3'($urandom),
                    $urandom_range(2) == 0);
  endfunction

  task automatic wait_drained(int extra);
    while (pending_writes.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_interval(logic [31:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    interval_ticks = v;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic run_phase(int n, int s_idle, int r_idle, logic [31:0] ivl);
    wait_drained(30);
    write_interval(ivl);
    snd_idle = s_idle;
    rcv_idle = r_idle;
    for (int i = 0; i < n; i++) add_write(random_req());
  endtask

  initial begin
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_wdata_i = 0;
    snd_idle = 0;
    rcv_idle = 0;
    tick = 32'hFFFF_FF80;
    key_pool[0] = 0;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < KeyPool; i++) key_pool[i] = $urandom;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    write_interval(0);

    // directed: extremes, every mode, full table, wrap of the tick counter
    add_write(make_req(MODE_MARK, 0, 1, 3'b111, 1));
    add_write(make_req(MODE_MARK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'b001, 0));
    add_write(make_req(MODE_MARK, 0, 0, 3'b000, 0));
    add_write(make_req(MODE_TAKE_URG, 0, 0, 3'b000, 0));
    add_write(make_req(MODE_TAKE_DUE, 0, 0, 3'b000, 0));
    add_write(make_req(MODE_RESTORE, 0, 1, 3'b110, 0));
    add_write(make_req(MODE_COMPLETE, 0, 1, 3'b111, 0));
    add_write(make_req(MODE_COMPLETE, 0, 1, 3'b111, 0));
    add_write(make_req(MODE_COMPLETE, 32'h1234_5678, 5, 3'b111, 0));
    add_write(make_req(MODE_RESTORE, 32'h0BAD_F00D, 7, 3'b010, 1));
    add_write(make_req(3'd5, 0, 0, 3'b000, 0));
    add_write(make_req(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'b111, 1));
    for (int i = 2; i < KeyPool; i++)
      add_write(make_req(MODE_MARK, key_pool[i], 3, 3'b101, 0));
    add_write(make_req(MODE_TAKE_DUE, 0, 0, 3'b000, 0));
    add_write(make_req(MODE_TAKE_URG, 0, 0, 3'b000, 0));

    run_phase(120, 10, 53, 5);
    run_phase(120, 53, 10, 32'hFFFF_FFFF);
    // no idling; a long receiver hold-off fills the block while writes keep coming
    run_phase(120, 0, 0, 40);
    long_stall_go = 1;
    wait_drained(30);
    write_interval($urandom_range(0, 3));
    for (int i = 0; i < 20; i++) add_write(random_req());
    wait_drained(40);

    $display("covered %0d transactions, %0d dispatched entries, %0d drops on a full table",
             items_done, entries_seen, full_drops);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
